@@ rtl/core/ucs2_hex_to_utf8_unit_assert.svh @@
// Assertion macros shared by the converter modules.
`ifndef UCS2_HEX_TO_UTF8_UNIT_ASSERT_SVH
`define UCS2_HEX_TO_UTF8_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCS2_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UCS2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ucs2h_pkg.sv @@
// Types and constants shared by the hex-to-UTF-8 converter modules.
package ucs2h_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       end_of_text;
  } out_word_t;

  typedef struct packed {
    logic [15:0] unit;
    logic [1:0]  nbytes;
    logic        last;
    logic [1:0]  status;
  } job_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;
  localparam logic [1:0] ST_NOTHING  = 2'd3;

  localparam logic [12:0] LIMIT_RESET = 13'd256;

  localparam logic [15:0] ONE_BYTE_TOP = 16'h0080;
  localparam logic [15:0] TWO_BYTE_TOP = 16'h0800;
  localparam logic [7:0]  LEAD_TWO     = 8'hC0;
  localparam logic [7:0]  LEAD_THREE   = 8'hE0;
  localparam logic [7:0]  CONT_MARK    = 8'h80;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPF   = 8'h46;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_LOWF  = 8'h66;

endpackage

@@ rtl/core/ucs2h_front.sv @@
// Front end: classifies characters, gathers code units and plans each word's output.
`include "ucs2_hex_to_utf8_unit_assert.svh"

module ucs2h_front #(
  parameter int HEX_CAPACITY = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_wdata,
  input  logic              acc_en,
  input  ucs2h_pkg::in_word_t in_word,
  output logic              job_push,
  output ucs2h_pkg::job_t   job
);

  localparam logic [10:0] CAP = 11'(HEX_CAPACITY);

  logic [12:0] limit_r;
  logic [9:0]  dc_r, dc_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        bad_r, bad_nxt;
  logic [12:0] be_r, be_nxt;

  logic        is_hex, is_blank, take, emit;
  logic [3:0]  hval;
  logic [15:0] acc_sh;
  logic [9:0]  dc_inc;
  logic [1:0]  nb;
  logic [1:0]  st;
  logic [7:0]  ch;

  always_comb begin
    ch = in_word.char_in;
    is_hex = 1'b1;
    hval = 4'd0;
    if (ch >= ucs2h_pkg::CH_DIG0 && ch <= ucs2h_pkg::CH_DIG9) begin
      hval = 4'(ch - ucs2h_pkg::CH_DIG0);
    end else if (ch >= ucs2h_pkg::CH_UPA && ch <= ucs2h_pkg::CH_UPF) begin
      hval = 4'(ch - ucs2h_pkg::CH_UPA + 8'd10);
    end else if (ch >= ucs2h_pkg::CH_LOWA && ch <= ucs2h_pkg::CH_LOWF) begin
      hval = 4'(ch - ucs2h_pkg::CH_LOWA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
    is_blank = (ch == ucs2h_pkg::CH_SPACE) || (ch == ucs2h_pkg::CH_TAB) ||
               (ch == ucs2h_pkg::CH_CR) || (ch == ucs2h_pkg::CH_LF);

    take   = !bad_r && (({1'b0, dc_r} + 11'd1) < CAP);
    dc_inc = dc_r + 10'd1;
    acc_sh = {acc_r[11:0], hval};

    if (acc_sh < ucs2h_pkg::ONE_BYTE_TOP) begin
      nb = 2'd1;
    end else if (acc_sh < ucs2h_pkg::TWO_BYTE_TOP) begin
      nb = 2'd2;
    end else begin
      nb = 2'd3;
    end

    emit = take && is_hex && (dc_inc[1:0] == 2'd0) &&
           (({1'b0, be_r} + 14'd4) < {1'b0, limit_r});

    dc_nxt  = (take && is_hex) ? dc_inc : dc_r;
    acc_nxt = (take && is_hex) ? acc_sh : acc_r;
    be_nxt  = emit ? (be_r + {11'd0, nb}) : be_r;
    bad_nxt = bad_r | (take && !is_hex && !is_blank);

    if (bad_nxt) begin
      st = ucs2h_pkg::ST_BAD_CHAR;
    end else if (dc_nxt < 10'd4 || dc_nxt[1:0] != 2'd0) begin
      st = ucs2h_pkg::ST_BAD_LEN;
    end else if (limit_r < 13'd2 || be_nxt == 13'd0) begin
      st = ucs2h_pkg::ST_NOTHING;
    end else begin
      st = ucs2h_pkg::ST_OK;
    end

    job.unit   = acc_sh;
    job.nbytes = emit ? nb : 2'd0;
    job.last   = in_word.last_char;
    job.status = st;
    job_push   = acc_en && (emit || in_word.last_char);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ucs2h_pkg::LIMIT_RESET;
      dc_r    <= '0;
      acc_r   <= '0;
      bad_r   <= 1'b0;
      be_r    <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (acc_en) begin
        if (in_word.last_char) begin
          dc_r  <= '0;
          acc_r <= '0;
          bad_r <= 1'b0;
          be_r  <= '0;
        end else begin
          dc_r  <= dc_nxt;
          acc_r <= acc_nxt;
          bad_r <= bad_nxt;
          be_r  <= be_nxt;
        end
      end
    end
  end

  `UCS2_ASSERT_NOW(a_dc_below_cap, 1'b1, ({1'b0, dc_r} < CAP), "digit count reached capacity")

endmodule

@@ rtl/core/ucs2h_fifo.sv @@
// Short show-ahead queue of planned words between the front and back ends.
`include "ucs2_hex_to_utf8_unit_assert.svh"

module ucs2h_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  ucs2h_pkg::job_t wr_data,
  input  logic            rd_en,
  output ucs2h_pkg::job_t rd_data,
  output logic            full,
  output logic            empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ucs2h_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `UCS2_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_r <= FULL_CNT), "queue count beyond depth")
  `UCS2_ASSERT_NOW(a_no_overrun, wr_en, !full, "word pushed into a full queue")

endmodule

@@ rtl/core/ucs2h_back.sv @@
// Back end: expands each planned word into UTF-8 bytes and a closing status.
`include "ucs2_hex_to_utf8_unit_assert.svh"

module ucs2h_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ucs2h_pkg::job_t       head,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output ucs2h_pkg::out_word_t  out_data
);

  logic                 ov_r;
  ucs2h_pkg::out_word_t od_r, res;
  logic [1:0]           idx_r;
  logic [2:0]           total;
  logic                 slot_free, advance, done;

  always_comb begin
    slot_free = !ov_r || pop;
    advance   = !q_empty && slot_free;
    total     = {1'b0, head.nbytes} + {2'b00, head.last};
    done      = (({1'b0, idx_r} + 3'd1) == total);
    q_pop     = advance && done;

    res = '0;
    if (idx_r < head.nbytes) begin
      res.byte_valid = 1'b1;
      case ({head.nbytes, idx_r})
        4'b01_00: res.out_byte = head.unit[7:0];
        4'b10_00: res.out_byte = ucs2h_pkg::LEAD_TWO | {3'b000, head.unit[10:6]};
        4'b10_01: res.out_byte = ucs2h_pkg::CONT_MARK | {2'b00, head.unit[5:0]};
        4'b11_00: res.out_byte = ucs2h_pkg::LEAD_THREE | {4'b0000, head.unit[15:12]};
        4'b11_01: res.out_byte = ucs2h_pkg::CONT_MARK | {2'b00, head.unit[11:6]};
        4'b11_10: res.out_byte = ucs2h_pkg::CONT_MARK | {2'b00, head.unit[5:0]};
        default:  res.out_byte = 8'd0;
      endcase
    end else begin
      res.status      = head.status;
      res.end_of_text = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (advance) begin
        ov_r  <= 1'b1;
        idx_r <= done ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      od_r <= res;
    end
  end

  assign empty    = !ov_r;
  assign out_data = od_r;

  `UCS2_ASSERT_NOW(a_status_clean, (ov_r && od_r.end_of_text),
    (!od_r.byte_valid && od_r.out_byte == 8'd0), "status word carries byte data")
  `UCS2_ASSERT_NEXT(a_idx_reset, q_pop, (idx_r == 2'd0), "byte index not rewound after word")

endmodule

@@ rtl/core/ucs2_hex_to_utf8_unit.sv @@
// Top level of the hex-coded UCS-2 to UTF-8 converter.
//
// Input queue side: a character word is taken at a rising edge with push high
// and full low; last_char marks the final character of a text.
// Result queue side: while empty is low the oldest result word is on out_data;
// it is taken at a rising edge with pop high. Data words carry one UTF-8 byte
// with byte_valid set; each text closes with one status word (end_of_text set).
// Configuration: cfg_we writes cfg_wdata into the output limit at once.
// One character is accepted every cycle while the word queue has room. The
// first result of a character passes through the word queue and then the back
// end's output register. The back end delivers one result word per cycle while
// the receiver pops, so a character giving three bytes and a status yields four
// result words; the word queue between front and back end absorbs such bursts.
// When the receiver stalls, the held result stays, the queue fills and full
// rises; nothing is lost.
// Reset clears the text state and both queues and sets the limit to 256.
module ucs2_hex_to_utf8_unit #(
  parameter int HEX_CAPACITY = 512,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_wdata,
  input  logic                 push,
  output logic                 full,
  input  ucs2h_pkg::in_word_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output ucs2h_pkg::out_word_t out_data
);

  ucs2h_pkg::job_t job, head;
  logic            job_push, q_full, q_empty, q_pop, acc_en;

  assign full   = q_full;
  assign acc_en = push && !q_full;

  ucs2h_front #(
    .HEX_CAPACITY(HEX_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .acc_en   (acc_en),
    .in_word  (in_data),
    .job_push (job_push),
    .job      (job)
  );

  ucs2h_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_data(job),
    .rd_en  (q_pop),
    .rd_data(head),
    .full   (q_full),
    .empty  (q_empty)
  );

  ucs2h_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_data(out_data)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the hex-coded UCS-2 to UTF-8 converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEX_CAPACITY = 512;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic      push = 1'b0;
  logic      full;
  ucs2h_pkg::in_word_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  ucs2h_pkg::out_word_t out_data;

  // Converter state as the block should hold it.
  int        hex_digits;
  logic [15:0] code_unit;
  bit        seen_bad_char;
  int        bytes_out;
  int        out_limit;

  ucs2h_pkg::out_word_t utf8_expected[$];
  logic [7:0] text_chars[$];
  int        errors;
  int        cycles;
  int        tx_idle_pct;
  int        rx_stall_pct;

  ucs2_hex_to_utf8_unit #(.HEX_CAPACITY(HEX_CAPACITY)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic expect_word(input logic [7:0] b, input logic v, input logic [1:0] st,
                             input logic eot);
    ucs2h_pkg::out_word_t w;
    w.out_byte    = b;
    w.byte_valid  = v;
    w.status      = st;
    w.end_of_text = eot;
    utf8_expected.push_back(w);
  endtask

  task automatic clear_text_state();
    hex_digits    = 0;
    code_unit     = '0;
    seen_bad_char = 1'b0;
    bytes_out     = 0;
  endtask

  task automatic decode_char(input ucs2h_pkg::in_word_t w);
    logic [7:0] c;
    logic [3:0] nib;
    bit         is_hex;
    logic [1:0] st;
    c      = w.char_in;
    is_hex = 1'b1;
    nib    = '0;
    if (!seen_bad_char && hex_digits + 1 < HEX_CAPACITY) begin
      if (c >= ucs2h_pkg::CH_DIG0 && c <= ucs2h_pkg::CH_DIG9)
        nib = 4'(c - ucs2h_pkg::CH_DIG0);
      else if (c >= ucs2h_pkg::CH_UPA && c <= ucs2h_pkg::CH_UPF)
        nib = 4'(c - ucs2h_pkg::CH_UPA + 8'd10);
      else if (c >= ucs2h_pkg::CH_LOWA && c <= ucs2h_pkg::CH_LOWF)
        nib = 4'(c - ucs2h_pkg::CH_LOWA + 8'd10);
      else is_hex = 1'b0;
      if (is_hex) begin
        code_unit = {code_unit[11:0], nib};
        hex_digits++;
        if (hex_digits % 4 == 0 && bytes_out + 4 < out_limit) begin
          if (code_unit < ucs2h_pkg::ONE_BYTE_TOP) begin
            expect_word(code_unit[7:0], 1'b1, ucs2h_pkg::ST_OK, 1'b0);
            bytes_out += 1;
          end else if (code_unit < ucs2h_pkg::TWO_BYTE_TOP) begin
            expect_word(ucs2h_pkg::LEAD_TWO | {3'b0, code_unit[10:6]}, 1'b1,
                        ucs2h_pkg::ST_OK, 1'b0);
            expect_word(ucs2h_pkg::CONT_MARK | {2'b0, code_unit[5:0]}, 1'b1,
                        ucs2h_pkg::ST_OK, 1'b0);
            bytes_out += 2;
          end else begin
            expect_word(ucs2h_pkg::LEAD_THREE | {4'b0, code_unit[15:12]}, 1'b1,
                        ucs2h_pkg::ST_OK, 1'b0);
            expect_word(ucs2h_pkg::CONT_MARK | {2'b0, code_unit[11:6]}, 1'b1,
                        ucs2h_pkg::ST_OK, 1'b0);
            expect_word(ucs2h_pkg::CONT_MARK | {2'b0, code_unit[5:0]}, 1'b1,
                        ucs2h_pkg::ST_OK, 1'b0);
            bytes_out += 3;
          end
        end
      end else if (c != ucs2h_pkg::CH_SPACE && c != ucs2h_pkg::CH_TAB &&
                   c != ucs2h_pkg::CH_CR && c != ucs2h_pkg::CH_LF) begin
        seen_bad_char = 1'b1;
      end
    end
    if (w.last_char) begin
      if (seen_bad_char) st = ucs2h_pkg::ST_BAD_CHAR;
      else if (hex_digits < 4 || hex_digits % 4 != 0) st = ucs2h_pkg::ST_BAD_LEN;
      else if (out_limit < 2 || bytes_out == 0) st = ucs2h_pkg::ST_NOTHING;
      else st = ucs2h_pkg::ST_OK;
      expect_word(8'h00, 1'b0, st, 1'b1);
      clear_text_state();
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk) begin : rx_check
    ucs2h_pkg::out_word_t want;
    if (rst_n && pop && !empty) begin
      if (utf8_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
      end else begin
        want = utf8_expected.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_field("out_byte", want.out_byte, out_data.out_byte);
        if (out_data.byte_valid !== want.byte_valid)
          report_field("byte_valid", want.byte_valid, out_data.byte_valid);
        if (out_data.status !== want.status)
          report_field("status", want.status, out_data.status);
        if (out_data.end_of_text !== want.end_of_text)
          report_field("end_of_text", want.end_of_text, out_data.end_of_text);
      end
    end
    if (!rst_n) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push              <= 1'b1;
    in_data.char_in   <= c;
    in_data.last_char <= last;
    do @(posedge clk); while (full);
    decode_char('{char_in: c, last_char: last});
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_chars.size(); i++)
      send_char(text_chars[i], i == text_chars.size() - 1);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input logic [12:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    out_limit = int'(v);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
    if (d < 10) return ucs2h_pkg::CH_DIG0 + 8'(d);
    return (upper ? ucs2h_pkg::CH_UPA : ucs2h_pkg::CH_LOWA) + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return ucs2h_pkg::CH_SPACE;
      1: return ucs2h_pkg::CH_TAB;
      2: return ucs2h_pkg::CH_CR;
      default: return ucs2h_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 8))
      0: return ucs2h_pkg::CH_DIG0 - 8'd1;
      1: return ucs2h_pkg::CH_DIG9 + 8'd1;
      2: return ucs2h_pkg::CH_UPA - 8'd1;
      3: return ucs2h_pkg::CH_UPF + 8'd1;
      4: return ucs2h_pkg::CH_LOWA - 8'd1;
      5: return ucs2h_pkg::CH_LOWF + 8'd1;
      6: return 8'h00;
      7: return 8'h80;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic build_random_text();
    int          units;
    bit          corrupt;
    logic [15:0] v;
    text_chars.delete();
    units   = $urandom_range(0, 6);
    corrupt = ($urandom_range(99) < 20);
    for (int u = 0; u < units; u++) begin
      case ($urandom_range(0, 2))
        0: v = 16'($urandom_range(0, 16'h007F));
        1: v = 16'($urandom_range(16'h0080, 16'h07FF));
        default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
      for (int n = 3; n >= 0; n--) begin
        if ($urandom_range(0, 11) == 0) text_chars.push_back(blank_char());
        if (corrupt && $urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 2))
            0: text_chars.push_back(noise_char());
            1: ;
            default: text_chars.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
          endcase
        end
        text_chars.push_back(hex_char(v[n*4 +: 4], 1'($urandom_range(0, 1))));
      end
    end
    if (corrupt && $urandom_range(0, 3) == 0) text_chars.push_back(noise_char());
    if (text_chars.size() == 0) text_chars.push_back(blank_char());
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Widths of every class, all four blanks, a surrogate, a zero unit, a bad character, a bad length and a blank text.
  task automatic test_directed();
    send_string("0041 07fF\tD800\r\n0000");
    send_string("0080 0800FFFF007f");
    send_string("0G1");
    send_string("008");
    send_string(" ");
    drain();
  endtask

  // Digits beyond the capacity are dropped, and so is a bad character after them.
  task automatic test_capacity();
    text_chars.delete();
    for (int i = 0; i < HEX_CAPACITY + 4; i++)
      text_chars.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
    text_chars.push_back(ucs2h_pkg::CH_UPF + 8'd1);
    send_text();
    drain();
  endtask

  task automatic test_output_limit();
    logic [12:0] limits[7] = '{13'd0, 13'd1, 13'd2, 13'd5, 13'd7, 13'h1FFF, 13'd4096};
    foreach (limits[i]) begin
      set_limit(limits[i]);
      send_string("0041 20AC00E9");
      send_string("FFFF");
      drain();
    end
  endtask

  task automatic test_random(input int chars_wanted);
    int sent;
    sent = 0;
    while (sent < chars_wanted) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        case ($urandom_range(0, 5))
          0: set_limit(13'($urandom_range(0, 3)));
          1: set_limit(13'($urandom_range(4, 12)));
          2: set_limit(13'($urandom_range(13, 40)));
          3: set_limit(ucs2h_pkg::LIMIT_RESET);
          4: set_limit(13'd4096);
          default: set_limit(13'h1FFF);
        endcase
      end
      build_random_text();
      send_text();
      sent += text_chars.size();
    end
    drain();
  endtask

  initial begin
    errors    = 0;
    cycles    = 0;
    out_limit = int'(ucs2h_pkg::LIMIT_RESET);
    clear_text_state();
    set_idling(0, 0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity();
    test_output_limit();
    set_limit(ucs2h_pkg::LIMIT_RESET);
    test_random(103);
    set_idling(77, 0);
    test_random(103);
    set_idling(0, 77);
    test_random(103);
    set_idling(19, 19);
    test_random(103);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ ucs2_hex_to_utf8_unit.f @@
+incdir+rtl/core
rtl/core/ucs2h_pkg.sv
rtl/core/ucs2h_front.sv
rtl/core/ucs2h_fifo.sv
rtl/core/ucs2h_back.sv
rtl/core/ucs2_hex_to_utf8_unit.sv
tb/testbench.sv
